>>> sv/assert_macros.svh
// assertion helpers on the block clock and reset
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds at every edge out of reset
`define ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) else $error(msg);

// consequent holds in the cycle after the antecedent
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> sv/arc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arc_pkg
// beat types and codes of the adaptive replacement policy directory
// ----------------------------------------------------------------------------
package arc_pkg;

    localparam logic [2:0] REQ_ACCESS = 3'd0;
    localparam logic [2:0] REQ_MISS   = 3'd1;
    localparam logic [2:0] REQ_LOAD   = 3'd2;
    localparam logic [2:0] REQ_EVICT  = 3'd3;
    localparam logic [2:0] REQ_VICTIM = 3'd4;

    localparam logic [1:0] ST_DONE   = 2'd0;
    localparam logic [1:0] ST_VICTIM = 2'd1;
    localparam logic [1:0] ST_FULL   = 2'd2;
    localparam logic [1:0] ST_OVF    = 2'd3;

    localparam logic [1:0] L_T1 = 2'd0;
    localparam logic [1:0] L_T2 = 2'd1;
    localparam logic [1:0] L_B1 = 2'd2;
    localparam logic [1:0] L_B2 = 2'd3;

    typedef struct packed {
        logic [2:0]  req_type;
        logic [31:0] page_id;
        logic [3:0]  frame_no;
        logic [15:0] evictable_mask;
    } t_req_beat;

    typedef struct packed {
        logic [1:0] status;
        logic [3:0] victim_frame;
    } t_rsp_beat;

endpackage

>>> sv/arc_page_replacement.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arc_page_replacement
// adaptive replacement cache directory: t1/t2 resident, b1/b2 ghost lists
// ----------------------------------------------------------------------------
// channel   dir  handshake              beat
// in        in   i_in_valid/o_in_stall  t_req_beat
// out       out  o_out_valid/i_out_stall t_rsp_beat
// cfg       in   i_cfg_valid/o_cfg_ready capacity
//
// one event at a time; each pass over the directory memory uses its one read
// port: lookup, then a rank update, victim scan or one pass per pruned ghost;
// miss adaptation adds a divider run and a target update.
// a rank-updating access runs lookup, decide, rank pass and done; load and
// evict then add a prune check, and each drop a further pass and check.
// reset is synchronous and clears valid bits, list counts and adaptive state.
// a result waits in the output register; the next event is taken meanwhile.
// ----------------------------------------------------------------------------
module arc_page_replacement
    import arc_pkg::*;
#(
    parameter int NUM_FRAMES   = 16,
    parameter int MAX_CAPACITY = 16,
    parameter int DIR_DEPTH    = 32,
    parameter int PAGE_ID_BITS = 32
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_req_beat i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_rsp_beat o_out_data,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [4:0] i_cfg_data
);
`include "assert_macros.svh"

    localparam int IW  = $clog2(DIR_DEPTH);
    localparam int CW  = $clog2(DIR_DEPTH + 1);
    localparam int TW  = $clog2(MAX_CAPACITY + 1);
    localparam int SW  = ((CW > TW) ? CW : TW) + 2;
    localparam int PW  = (PAGE_ID_BITS < 32) ? PAGE_ID_BITS : 32;

    typedef struct packed {
        logic [PW-1:0] page;
        logic [1:0]    lst;
        logic [IW-1:0] rank;
        logic [3:0]    frame;
        logic          resident;
    } t_entry;

    typedef enum logic [10:0] {
        S_IDLE   = 11'b00000000001,
        S_FIND   = 11'b00000000010,
        S_DECIDE = 11'b00000000100,
        S_UPD    = 11'b00000001000,
        S_PRUNE  = 11'b00000010000,
        S_DROP   = 11'b00000100000,
        S_DIV    = 11'b00001000000,
        S_ADAPT  = 11'b00010000000,
        S_PICK   = 11'b00100000000,
        S_CHOOSE = 11'b01000000000,
        S_DONE   = 11'b10000000000
    } t_state;

    t_state r_state;

    t_entry mem [DIR_DEPTH];
    t_entry r_rdata;
    logic [DIR_DEPTH-1:0] r_valid;

    logic [CW-1:0] r_sw;
    logic          r_pv;
    logic [IW-1:0] r_pidx;
    logic [IW-1:0] rd_addr;
    logic          sweep_done;
    logic          in_sweep;

    logic [CW-1:0] r_lcnt [4];
    logic [TW-1:0] r_cap;
    logic [TW-1:0] r_target;
    logic          r_pending;

    logic [2:0]    r_req;
    logic [PW-1:0] r_page;
    logic [3:0]    r_frame;
    logic [15:0]   r_mask;

    logic          r_hit;
    logic [IW-1:0] r_e;
    t_entry        r_erec;
    logic          r_free_ok;
    logic [IW-1:0] r_free;

    t_entry        r_newrec;
    logic          r_unlink;
    logic [1:0]    r_lold;
    logic [1:0]    r_lnew;
    logic          r_prune_after;
    logic [CW-1:0] upd_cnt [4];

    logic [1:0]    r_dl;
    logic [IW-1:0] r_dtgt;
    logic          r_dfound;

    logic          r_b1ok, r_b2ok;
    logic [IW-1:0] r_b1rank, r_b2rank;
    logic [3:0]    r_b1frame, r_b2frame;

    logic          r_up;
    logic          div_start;
    logic [CW-1:0] div_num, div_den, div_quo;
    logic          div_done;

    logic [1:0]    r_status;
    logic [3:0]    r_victim;
    logic          r_out_valid;
    t_rsp_beat     r_out;

    logic          mem_we;
    logic [IW-1:0] mem_wa;
    t_entry        mem_wd;
    logic [4:0]    cfg_v;
    logic [TW-1:0] cfg_cap;

    logic          vj, is_e, cand;
    logic [IW-1:0] upd_rank;
    logic [SW-1:0] c1, c2, capw, tgtw, qd, tsum;

    function automatic logic evictable(input logic [3:0] f, input logic [15:0] m);
        return (NUM_FRAMES > int'(f)) && m[f];
    endfunction

    arc_divider #(.W(CW)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_quo   (div_quo)
    );

    assign in_sweep   = (r_state == S_FIND) || (r_state == S_UPD) ||
                        (r_state == S_DROP) || (r_state == S_PICK);
    assign rd_addr    = (r_sw < CW'(DIR_DEPTH)) ? r_sw[IW-1:0] : '0;
    assign sweep_done = (r_sw == CW'(DIR_DEPTH)) && !r_pv;
    assign vj         = r_valid[r_pidx];
    assign is_e       = (r_pidx == r_e);
    assign cand       = vj && r_rdata.resident && evictable(r_rdata.frame, r_mask);

    assign c1   = SW'(r_lcnt[L_B1]);
    assign c2   = SW'(r_lcnt[L_B2]);
    assign capw = SW'(r_cap);
    assign tgtw = SW'(r_target);
    assign qd   = (div_quo == '0) ? SW'(1) : SW'(div_quo);
    assign tsum = tgtw + qd;

    assign cfg_v   = (i_cfg_data == 5'd0) ? 5'd1 : i_cfg_data;
    assign cfg_cap = (int'(cfg_v) > MAX_CAPACITY) ? TW'(MAX_CAPACITY) : TW'(cfg_v);

    assign div_start = (r_state == S_DECIDE) && (r_req == REQ_MISS) && r_hit &&
                       ((r_erec.lst == L_B1) || (r_erec.lst == L_B2));
    assign div_num   = (r_erec.lst == L_B1) ? r_lcnt[L_B2] : r_lcnt[L_B1];
    always_comb begin
        div_den = (r_erec.lst == L_B1) ? r_lcnt[L_B1] : r_lcnt[L_B2];
        if (div_den == '0) begin
            div_den = CW'(1);
        end
    end

    always_comb begin
        upd_rank = r_rdata.rank;
        if (r_unlink && (r_rdata.lst == r_lold) && (r_rdata.rank > r_erec.rank)) begin
            upd_rank = upd_rank - 1'b1;
        end
        if (r_rdata.lst == r_lnew) begin
            upd_rank = upd_rank + 1'b1;
        end
    end

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            upd_cnt[k] = r_lcnt[k];
            if (r_unlink && (r_lold == 2'(k)) && (r_lcnt[k] != '0)) begin
                upd_cnt[k] = upd_cnt[k] - 1'b1;
            end
            if (r_lnew == 2'(k)) begin
                upd_cnt[k] = upd_cnt[k] + 1'b1;
            end
        end
    end

    // write port: rank pass or a single entry update
    always_comb begin
        mem_we = 1'b0;
        mem_wa = r_pidx;
        mem_wd = r_rdata;
        if (r_state == S_UPD && r_pv) begin
            mem_we = 1'b1;
            if (is_e) begin
                mem_wd = r_newrec;
            end else if (vj) begin
                mem_wd.rank = upd_rank;
            end
        end else if (r_state == S_DECIDE && r_hit &&
                     ((r_erec.lst == L_B1) || (r_erec.lst == L_B2)) &&
                     ((r_req == REQ_ACCESS) || (r_req == REQ_EVICT))) begin
            mem_we = 1'b1;
            mem_wa = r_e;
            mem_wd = r_erec;
            if (r_req == REQ_ACCESS) begin
                mem_wd.frame    = r_frame;
                mem_wd.resident = 1'b1;
            end else begin
                mem_wd.resident = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
        r_rdata <= mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_valid     <= '0;
            r_sw        <= '0;
            r_pv        <= 1'b0;
            r_cap       <= TW'(MAX_CAPACITY);
            r_target    <= '0;
            r_pending   <= 1'b0;
            r_out_valid <= 1'b0;
            for (int k = 0; k < 4; k++) begin
                r_lcnt[k] <= '0;
            end
        end else begin
            if (in_sweep) begin
                r_pv   <= (r_sw < CW'(DIR_DEPTH));
                r_pidx <= r_sw[IW-1:0];
                if (r_sw < CW'(DIR_DEPTH)) begin
                    r_sw <= r_sw + 1'b1;
                end
            end else begin
                r_sw <= '0;
                r_pv <= 1'b0;
            end

            if (r_out_valid && !i_out_stall && (r_state != S_DONE)) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (i_cfg_valid) begin
                        r_cap     <= cfg_cap;
                        r_valid   <= '0;
                        r_target  <= '0;
                        r_pending <= 1'b0;
                        for (int k = 0; k < 4; k++) begin
                            r_lcnt[k] <= '0;
                        end
                    end else if (i_in_valid) begin
                        r_req     <= i_in_data.req_type;
                        r_page    <= i_in_data.page_id[PW-1:0];
                        r_frame   <= i_in_data.frame_no;
                        r_mask    <= i_in_data.evictable_mask;
                        r_hit     <= 1'b0;
                        r_free_ok <= 1'b0;
                        r_status  <= ST_DONE;
                        r_victim  <= '0;
                        r_state   <= S_FIND;
                    end
                end
                S_FIND: begin
                    if (r_pv) begin
                        if (vj && (r_rdata.page == r_page) && !r_hit) begin
                            r_hit  <= 1'b1;
                            r_e    <= r_pidx;
                            r_erec <= r_rdata;
                        end
                        if (!vj && !r_free_ok) begin
                            r_free_ok <= 1'b1;
                            r_free    <= r_pidx;
                        end
                    end
                    if (sweep_done) begin
                        r_state <= S_DECIDE;
                    end
                end
                S_DECIDE: begin
                    r_unlink      <= r_hit;
                    r_lold        <= r_erec.lst;
                    r_prune_after <= (r_req == REQ_LOAD) || (r_req == REQ_EVICT);
                    r_newrec.page     <= r_page;
                    r_newrec.rank     <= '0;
                    r_newrec.frame    <= ((r_req == REQ_ACCESS) || (r_req == REQ_LOAD)) ?
                                         r_frame : (r_hit ? r_erec.frame : 4'd0);
                    r_newrec.resident <= (r_req != REQ_EVICT);
                    case (r_req)
                        REQ_ACCESS, REQ_LOAD: begin
                            if (!r_hit) begin
                                if (!r_free_ok) begin
                                    r_status <= ST_OVF;
                                    r_state  <= S_DONE;
                                end else begin
                                    r_e              <= r_free;
                                    r_valid[r_free]  <= 1'b1;
                                    r_lnew           <= L_T1;
                                    r_newrec.lst     <= L_T1;
                                    r_state          <= S_UPD;
                                end
                            end else if ((r_erec.lst == L_B1) || (r_erec.lst == L_B2)) begin
                                if (r_req == REQ_LOAD) begin
                                    r_lnew       <= L_T2;
                                    r_newrec.lst <= L_T2;
                                    r_state      <= S_UPD;
                                end else begin
                                    r_state <= S_DONE;
                                end
                            end else begin
                                r_lnew       <= (r_req == REQ_LOAD) ? L_T1 : L_T2;
                                r_newrec.lst <= (r_req == REQ_LOAD) ? L_T1 : L_T2;
                                r_state      <= S_UPD;
                            end
                        end
                        REQ_MISS: begin
                            r_pending <= 1'b0;
                            if (div_start) begin
                                r_up    <= (r_erec.lst == L_B1);
                                r_state <= S_DIV;
                            end else begin
                                r_state <= S_DONE;
                            end
                        end
                        REQ_EVICT: begin
                            if (!r_hit) begin
                                r_state <= S_DONE;
                            end else if (r_erec.lst == L_T1) begin
                                r_lnew       <= L_B1;
                                r_newrec.lst <= L_B1;
                                r_state      <= S_UPD;
                            end else if (r_erec.lst == L_T2) begin
                                r_lnew       <= L_B2;
                                r_newrec.lst <= L_B2;
                                r_state      <= S_UPD;
                            end else begin
                                r_state <= S_PRUNE;
                            end
                        end
                        REQ_VICTIM: begin
                            r_b1ok  <= 1'b0;
                            r_b2ok  <= 1'b0;
                            r_state <= S_PICK;
                        end
                        default: begin
                            r_state <= S_DONE;
                        end
                    endcase
                end
                S_UPD: begin
                    if (sweep_done) begin
                        for (int k = 0; k < 4; k++) begin
                            r_lcnt[k] <= upd_cnt[k];
                        end
                        r_state <= r_prune_after ? S_PRUNE : S_DONE;
                    end
                end
                S_PRUNE: begin
                    r_dfound <= 1'b0;
                    if (c1 > capw) begin
                        r_dl    <= L_B1;
                        r_dtgt  <= IW'(r_lcnt[L_B1] - 1'b1);
                        r_state <= S_DROP;
                    end else if (c2 > capw) begin
                        r_dl    <= L_B2;
                        r_dtgt  <= IW'(r_lcnt[L_B2] - 1'b1);
                        r_state <= S_DROP;
                    end else if (c1 + c2 > capw) begin
                        r_dl    <= (c1 >= c2) ? L_B1 : L_B2;
                        r_dtgt  <= (c1 >= c2) ? IW'(r_lcnt[L_B1] - 1'b1)
                                              : IW'(r_lcnt[L_B2] - 1'b1);
                        r_state <= S_DROP;
                    end else begin
                        r_state <= S_DONE;
                    end
                end
                S_DROP: begin
                    if (r_pv && vj && (r_rdata.lst == r_dl) && (r_rdata.rank == r_dtgt) &&
                        !r_dfound) begin
                        r_valid[r_pidx] <= 1'b0;
                        r_dfound        <= 1'b1;
                    end
                    if (sweep_done) begin
                        if (r_dfound) begin
                            r_lcnt[r_dl] <= r_lcnt[r_dl] - 1'b1;
                            r_state      <= S_PRUNE;
                        end else begin
                            r_state <= S_DONE;
                        end
                    end
                end
                S_DIV: begin
                    if (div_done) begin
                        r_state <= S_ADAPT;
                    end
                end
                S_ADAPT: begin
                    if (r_up) begin
                        r_target <= (tsum < capw) ? TW'(tsum) : r_cap;
                    end else begin
                        r_target  <= (tgtw > qd) ? TW'(tgtw - qd) : '0;
                        r_pending <= 1'b1;
                    end
                    r_state <= S_DONE;
                end
                S_PICK: begin
                    if (r_pv && cand) begin
                        if ((r_rdata.lst == L_T1) && (!r_b1ok || r_rdata.rank > r_b1rank)) begin
                            r_b1ok    <= 1'b1;
                            r_b1rank  <= r_rdata.rank;
                            r_b1frame <= r_rdata.frame;
                        end
                        if ((r_rdata.lst == L_T2) && (!r_b2ok || r_rdata.rank > r_b2rank)) begin
                            r_b2ok    <= 1'b1;
                            r_b2rank  <= r_rdata.rank;
                            r_b2frame <= r_rdata.frame;
                        end
                    end
                    if (sweep_done) begin
                        r_state <= S_CHOOSE;
                    end
                end
                S_CHOOSE: begin
                    if (((SW'(r_lcnt[L_T1]) > tgtw) ||
                         (r_pending && (SW'(r_lcnt[L_T1]) == tgtw))) && r_b1ok) begin
                        r_status <= ST_VICTIM;
                        r_victim <= r_b1frame;
                    end else if (r_b2ok) begin
                        r_status <= ST_VICTIM;
                        r_victim <= r_b2frame;
                    end else if (r_b1ok) begin
                        r_status <= ST_VICTIM;
                        r_victim <= r_b1frame;
                    end else begin
                        r_status <= ST_FULL;
                    end
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (!r_out_valid || !i_out_stall) begin
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_DONE && (!r_out_valid || !i_out_stall)) begin
            r_out.status       <= r_status;
            r_out.victim_frame <= r_victim;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE) || i_cfg_valid;
    assign o_cfg_ready = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    `ASSERT_ALWAYS(a_target_le_cap, r_target <= r_cap, "target above capacity")
    `ASSERT_ALWAYS(a_count_le_depth,
        (SW'(r_lcnt[0]) + SW'(r_lcnt[1]) + SW'(r_lcnt[2]) + SW'(r_lcnt[3])) <=
        SW'(DIR_DEPTH), "list counts exceed directory")
    `ASSERT_NEXT(a_cfg_clears, i_cfg_valid && o_cfg_ready, r_valid == '0,
        "directory not cleared by capacity write")
    `ASSERT_NEXT(a_victim_range, r_state == S_CHOOSE,
        (r_status != ST_VICTIM) || (NUM_FRAMES > int'(r_victim)),
        "victim frame out of pool")

endmodule

>>> sv/arc_divider.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arc_divider
// restoring unsigned divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module arc_divider #(
    parameter int W = 6
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_start,
    input  logic [W-1:0] i_num,
    input  logic [W-1:0] i_den,
    output logic         o_done,
    output logic [W-1:0] o_quo
);
    localparam int SCW = $clog2(W + 1);

    logic [W:0]     r_rem;
    logic [W-1:0]   r_q;
    logic [W-1:0]   r_den;
    logic [SCW-1:0] r_step;
    logic           r_busy;
    logic           r_done;
    logic [W:0]     try_rem;

    assign try_rem = {r_rem[W-1:0], r_q[W-1]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_rem  <= '0;
                r_q    <= i_num;
                r_den  <= i_den;
                r_step <= SCW'(W);
            end else if (r_busy) begin
                if (try_rem >= {1'b0, r_den}) begin
                    r_rem <= try_rem - {1'b0, r_den};
                    r_q   <= {r_q[W-2:0], 1'b1};
                end else begin
                    r_rem <= try_rem;
                    r_q   <= {r_q[W-2:0], 1'b0};
                end
                r_step <= r_step - 1'b1;
                if (r_step == SCW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_q;

endmodule
